// ----- hw/rtl/buddy_block_allocator_core_assert.svh -----
// Assertion macros of the buddy allocator RTL, used by bba_datapath.
// Needs a clock named clk and an active-high reset named rst in scope.
`ifndef BUDDY_BLOCK_ALLOCATOR_CORE_ASSERT_SVH
`define BUDDY_BLOCK_ALLOCATOR_CORE_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define BBA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define BBA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define BBA_ASSERT(lbl, prop, msg)
`define BBA_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// ----- hw/rtl/bba_pkg.sv -----
// Shared types and constants of the buddy block allocator.
// Used by bba_ctrl, bba_datapath and buddy_block_allocator_core.
`default_nettype none
package bba_pkg;

  localparam int DEF_TOP_BLOCKS  = 32;
  localparam int DEF_TOP_ORDER   = 10;
  localparam int MIN_SHIFT       = 7;
  localparam int MIN_BLOCK_BYTES = 1 << MIN_SHIFT;

  localparam int REQ_W    = 20;
  localparam int FU_W     = 15;
  localparam int HDR_W    = 7;
  localparam int OFF_W    = 22;
  localparam int ORD_W    = 4;
  localparam int STATUS_W = 2;

  localparam logic [HDR_W-1:0] HDR_RESET = 7'd48;
  localparam logic [ORD_W-1:0] NO_ORDER  = 4'hF;

  typedef enum logic [0:0] {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_NOFREE  = 2'd1,
    ST_BADSIZE = 2'd2,
    ST_BADFREE = 2'd3
  } status_t;

  typedef enum logic [4:0] {
    CMD_NONE,
    CMD_CLEAR,
    CMD_LOAD,
    CMD_SCAN_INIT,
    CMD_SCAN_RD,
    CMD_SCAN_NEXT,
    CMD_SCAN_HIT,
    CMD_LVL_STEP,
    CMD_TAKE,
    CMD_SPLIT_RD,
    CMD_SPLIT_WR,
    CMD_AO_WR,
    CMD_FREE_RD,
    CMD_FREE_TAKE,
    CMD_MRG_RD,
    CMD_MRG_EV,
    CMD_SET_RD,
    CMD_SET_WR,
    CMD_RESULT
  } cmd_t;

  typedef enum logic [4:0] {
    S_CLEAR,
    S_IDLE,
    S_CHECK,
    S_SCAN_RD,
    S_SCAN_EV,
    S_LVL,
    S_TAKE,
    S_SPLIT,
    S_SPLIT_WR,
    S_AO_WR,
    S_FREE_RD,
    S_FREE_CHK,
    S_MRG,
    S_MRG_EV,
    S_SET_RD,
    S_SET_WR,
    S_RES
  } state_t;

  typedef struct packed {
    cmd_t    op;
    status_t res_status;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clr_done;
    logic is_free;
    logic bad_size;
    logic bad_unit;
    logic scan_hit;
    logic scan_last;
    logic lvl_done;
    logic split_done;
    logic ao_none;
    logic ord_top;
    logic buddy_free;
    logic slot_free;
  } dp_status_t;

endpackage
`default_nettype wire

// ----- hw/rtl/bba_ctrl.sv -----
// Sequencer of the buddy allocator: walks each request through the
// datapath by commands. Depends on bba_pkg.
`default_nettype none
module bba_ctrl (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 in_valid,
  output logic                in_ready,
  input  bba_pkg::dp_status_t st,
  output bba_pkg::ctrl_cmd_t  cmd
);
  import bba_pkg::*;

  state_t  state, state_next;
  status_t res_code, res_code_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      res_code <= ST_OK;
    end else begin
      state    <= state_next;
      res_code <= res_code_next;
    end
  end

  always_comb begin
    state_next     = state;
    res_code_next  = res_code;
    cmd.op         = CMD_NONE;
    cmd.res_status = res_code;
    in_ready       = 1'b0;
    case (state)
      S_CLEAR: begin
        cmd.op = CMD_CLEAR;
        if (st.clr_done) state_next = S_IDLE;
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op     = CMD_LOAD;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (st.is_free) begin
          if (st.bad_unit) begin
            res_code_next = ST_BADFREE;
            state_next    = S_RES;
          end else begin
            state_next = S_FREE_RD;
          end
        end else if (st.bad_size) begin
          res_code_next = ST_BADSIZE;
          state_next    = S_RES;
        end else begin
          cmd.op     = CMD_SCAN_INIT;
          state_next = S_SCAN_RD;
        end
      end
      S_SCAN_RD: begin
        cmd.op     = CMD_SCAN_RD;
        state_next = S_SCAN_EV;
      end
      S_SCAN_EV: begin
        if (st.scan_hit) begin
          cmd.op     = CMD_SCAN_HIT;
          state_next = S_LVL;
        end else if (st.scan_last) begin
          res_code_next = ST_NOFREE;
          state_next    = S_RES;
        end else begin
          cmd.op     = CMD_SCAN_NEXT;
          state_next = S_SCAN_RD;
        end
      end
      S_LVL: begin
        if (st.lvl_done) state_next = S_TAKE;
        else cmd.op = CMD_LVL_STEP;
      end
      S_TAKE: begin
        cmd.op     = CMD_TAKE;
        state_next = S_SPLIT;
      end
      S_SPLIT: begin
        if (st.split_done) begin
          state_next = S_AO_WR;
        end else begin
          cmd.op     = CMD_SPLIT_RD;
          state_next = S_SPLIT_WR;
        end
      end
      S_SPLIT_WR: begin
        cmd.op     = CMD_SPLIT_WR;
        state_next = S_SPLIT;
      end
      S_AO_WR: begin
        cmd.op        = CMD_AO_WR;
        res_code_next = ST_OK;
        state_next    = S_RES;
      end
      S_FREE_RD: begin
        cmd.op     = CMD_FREE_RD;
        state_next = S_FREE_CHK;
      end
      S_FREE_CHK: begin
        if (st.ao_none) begin
          res_code_next = ST_BADFREE;
          state_next    = S_RES;
        end else begin
          cmd.op     = CMD_FREE_TAKE;
          state_next = S_MRG;
        end
      end
      S_MRG: begin
        if (st.ord_top) begin
          state_next = S_SET_RD;
        end else begin
          cmd.op     = CMD_MRG_RD;
          state_next = S_MRG_EV;
        end
      end
      S_MRG_EV: begin
        if (st.buddy_free) begin
          cmd.op     = CMD_MRG_EV;
          state_next = S_MRG;
        end else begin
          state_next = S_SET_RD;
        end
      end
      S_SET_RD: begin
        cmd.op     = CMD_SET_RD;
        state_next = S_SET_WR;
      end
      S_SET_WR: begin
        cmd.op        = CMD_SET_WR;
        res_code_next = ST_OK;
        state_next    = S_RES;
      end
      S_RES: begin
        if (st.slot_free) begin
          cmd.op     = CMD_RESULT;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_CLEAR;
    endcase
  end

endmodule
`default_nettype wire

// ----- hw/rtl/bba_datapath.sv -----
// Datapath of the buddy allocator: free map and order memories, search,
// split and merge arithmetic, and the result register. Depends on bba_pkg.
`default_nettype none
`include "buddy_block_allocator_core_assert.svh"
module bba_datapath #(
  parameter int TOP_BLOCKS = bba_pkg::DEF_TOP_BLOCKS,
  parameter int TOP_ORDER  = bba_pkg::DEF_TOP_ORDER
) (
  input  wire                          clk,
  input  wire                          rst,
  input  bba_pkg::ctrl_cmd_t           cmd,
  output bba_pkg::dp_status_t          st,
  input  wire                          cfg_valid,
  input  wire  [bba_pkg::HDR_W-1:0]    cfg_data,
  input  wire                          in_op,
  input  wire  [bba_pkg::REQ_W-1:0]    in_req,
  input  wire  [bba_pkg::FU_W-1:0]     in_fu,
  output logic                         out_valid,
  input  wire                          out_ready,
  output logic [bba_pkg::STATUS_W-1:0] out_status,
  output logic [bba_pkg::FU_W-1:0]     out_unit,
  output logic [bba_pkg::OFF_W-1:0]    out_off,
  output logic [bba_pkg::ORD_W-1:0]    out_ord
);
  import bba_pkg::*;

  localparam int POOL_UNITS = TOP_BLOCKS << TOP_ORDER;
  localparam int MAP_BITS   = 2 * POOL_UNITS;
  localparam int UNIT_W     = $clog2(POOL_UNITS);
  localparam int MAP_AW     = $clog2(MAP_BITS);
  localparam int WAW        = MAP_AW - 5;
  localparam int MAP_DEPTH  = 1 << WAW;
  localparam int AO_DEPTH   = 1 << UNIT_W;
  localparam int LAST_WORD  = (MAP_BITS - 1) / 32;
  localparam int TOP_BYTES  = MIN_BLOCK_BYTES << TOP_ORDER;

  // Start bit of an order's region; regions of rising order follow each other.
  function automatic logic [MAP_AW-1:0] lvl_base(input logic [ORD_W-1:0] k);
    logic [MAP_AW:0] full;
    full = (MAP_AW+1)'(MAP_BITS) - (((MAP_AW+1)'(POOL_UNITS) >> k) << 1);
    return full[MAP_AW-1:0];
  endfunction

  function automatic logic [31:0] reset_word(input logic [WAW-1:0] w);
    logic [31:0]       v;
    logic [MAP_AW-1:0] pos;
    logic [MAP_AW-1:0] tb;
    tb = lvl_base(ORD_W'(TOP_ORDER));
    for (int j = 0; j < 32; j++) begin
      pos  = {w, 5'(j)};
      v[j] = (pos >= tb) && (32'(pos) < 32'(tb) + 32'(TOP_BLOCKS));
    end
    return v;
  endfunction

  logic [31:0]       map_mem [MAP_DEPTH];
  logic [ORD_W-1:0]  ao_mem  [AO_DEPTH];

  logic [HDR_W-1:0]  hdr;
  logic              is_free, bad_size, bad_unit;
  logic [ORD_W-1:0]  ord, lvl;
  logic [WAW-1:0]    waddr;
  logic [MAP_AW-1:0] p, wpos;
  logic [UNIT_W-1:0] unit, clr;
  logic [31:0]       map_q;
  logic [ORD_W-1:0]  ao_q;

  logic [REQ_W:0]    need;
  logic [ORD_W-1:0]  ord_c;
  logic              bad_size_c;
  logic [MAP_AW-1:0] base_ord, split_pos, buddy_pos, own_pos;
  logic [31:0]       lo_mask, masked, wbit;
  logic [4:0]        hit_idx;
  logic [ORD_W-1:0]  lvl_m1;

  logic              map_we, map_re, ao_we, ao_re;
  logic [WAW-1:0]    map_wa, map_ra;
  logic [31:0]       map_wd;
  logic [UNIT_W-1:0] ao_wa;
  logic [ORD_W-1:0]  ao_wd;

  always_comb begin
    need = (REQ_W+1)'(in_req) + (REQ_W+1)'(hdr);
    bad_size_c = (in_req == '0) || (32'(in_req) >= 32'(TOP_BYTES))
               || (32'(need) > 32'(TOP_BYTES));
    ord_c = '0;
    for (int k = 0; k <= TOP_ORDER; k++) begin
      if ((32'(MIN_BLOCK_BYTES) << k) < 32'(need)) ord_c = ORD_W'(k + 1);
    end
  end

  always_comb begin
    base_ord = lvl_base(ord);
    lo_mask  = (waddr == WAW'(base_ord >> 5)) ? (32'hFFFF_FFFF << base_ord[4:0])
                                               : 32'hFFFF_FFFF;
    masked   = map_q & lo_mask;
    hit_idx  = '0;
    for (int j = 31; j >= 0; j--) begin
      if (masked[j]) hit_idx = 5'(j);
    end
    lvl_m1    = lvl - 1'b1;
    split_pos = lvl_base(lvl_m1) + MAP_AW'(unit >> lvl_m1) + 1'b1;
    buddy_pos = base_ord + MAP_AW'((unit ^ (UNIT_W'(1) << ord)) >> ord);
    own_pos   = base_ord + MAP_AW'(unit >> ord);
    wbit      = 32'd1 << wpos[4:0];
  end

  always_comb begin
    st.clr_done   = (clr == '1);
    st.is_free    = is_free;
    st.bad_size   = bad_size;
    st.bad_unit   = bad_unit;
    st.scan_hit   = |masked;
    st.scan_last  = (waddr == WAW'(LAST_WORD));
    st.lvl_done   = (lvl == ORD_W'(TOP_ORDER)) || (p < lvl_base(lvl + 1'b1));
    st.split_done = (lvl == ord);
    st.ao_none    = (ao_q == NO_ORDER);
    st.ord_top    = (ord == ORD_W'(TOP_ORDER));
    st.buddy_free = map_q[wpos[4:0]];
    st.slot_free  = !out_valid || out_ready;
  end

  // Memory port selection.
  always_comb begin
    map_we = 1'b0;
    map_wa = WAW'(wpos >> 5);
    map_wd = map_q;
    map_re = 1'b0;
    map_ra = waddr;
    ao_we  = 1'b0;
    ao_wa  = unit;
    ao_wd  = NO_ORDER;
    ao_re  = 1'b0;
    case (cmd.op)
      CMD_CLEAR: begin
        map_we = 1'b1;
        map_wa = clr[WAW-1:0];
        map_wd = reset_word(clr[WAW-1:0]);
        ao_we  = 1'b1;
        ao_wa  = clr;
      end
      CMD_SCAN_RD:  map_re = 1'b1;
      CMD_SPLIT_RD: begin
        map_re = 1'b1;
        map_ra = WAW'(split_pos >> 5);
      end
      CMD_MRG_RD: begin
        map_re = 1'b1;
        map_ra = WAW'(buddy_pos >> 5);
      end
      CMD_SET_RD: begin
        map_re = 1'b1;
        map_ra = WAW'(own_pos >> 5);
      end
      CMD_TAKE, CMD_MRG_EV: begin
        map_we = 1'b1;
        map_wd = map_q & ~wbit;
      end
      CMD_SPLIT_WR, CMD_SET_WR: begin
        map_we = 1'b1;
        map_wd = map_q | wbit;
      end
      CMD_AO_WR: begin
        ao_we = 1'b1;
        ao_wd = ord;
      end
      CMD_FREE_TAKE: ao_we = 1'b1;
      CMD_FREE_RD:   ao_re = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (map_we) map_mem[map_wa] <= map_wd;
    if (map_re) map_q <= map_mem[map_ra];
  end

  always_ff @(posedge clk) begin
    if (ao_we) ao_mem[ao_wa] <= ao_wd;
    if (ao_re) ao_q <= ao_mem[unit];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hdr       <= HDR_RESET;
      clr       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid) hdr <= cfg_data;
      if (cmd.op == CMD_CLEAR) clr <= clr + 1'b1;
      if (cmd.op == CMD_RESULT) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      CMD_LOAD: begin
        is_free  <= (in_op == OP_FREE);
        bad_size <= bad_size_c;
        bad_unit <= (32'(in_fu) >= 32'(POOL_UNITS));
        ord      <= ord_c;
        unit     <= UNIT_W'(in_fu);
      end
      CMD_SCAN_INIT: waddr <= WAW'(base_ord >> 5);
      CMD_SCAN_NEXT: waddr <= waddr + 1'b1;
      CMD_SCAN_HIT: begin
        p    <= {waddr, hit_idx};
        wpos <= {waddr, hit_idx};
        lvl  <= ord;
      end
      CMD_LVL_STEP: lvl <= lvl + 1'b1;
      CMD_TAKE:     unit <= UNIT_W'((p - lvl_base(lvl)) << lvl);
      CMD_SPLIT_RD: begin
        wpos <= split_pos;
        lvl  <= lvl_m1;
      end
      CMD_FREE_TAKE: ord <= ao_q;
      CMD_MRG_RD:    wpos <= buddy_pos;
      CMD_MRG_EV: begin
        unit <= unit & ~(UNIT_W'(1) << ord);
        ord  <= ord + 1'b1;
      end
      CMD_SET_RD: wpos <= own_pos;
      CMD_RESULT: begin
        out_status <= cmd.res_status;
        if (cmd.res_status == ST_OK) begin
          out_unit <= FU_W'(unit);
          out_off  <= OFF_W'((32'(unit) << MIN_SHIFT) + 32'(hdr));
          out_ord  <= ord;
        end else begin
          out_unit <= '0;
          out_off  <= '0;
          out_ord  <= '0;
        end
      end
      default: ;
    endcase
  end

  `BBA_ASSERT(a_take_is_free, (cmd.op == CMD_TAKE) |-> map_q[wpos[4:0]], "taken block not free")
  `BBA_ASSERT(a_split_was_used, (cmd.op == CMD_SPLIT_WR) |-> !map_q[wpos[4:0]], "split half already free")
  `BBA_ASSERT(a_set_was_used, (cmd.op == CMD_SET_WR) |-> !map_q[wpos[4:0]], "freed block already free")
  `BBA_ASSERT_ALWAYS(a_rst_no_result, rst |=> !out_valid, "result valid after reset")

endmodule
`default_nettype wire

// ----- hw/rtl/buddy_block_allocator_core.sv -----
// Buddy block allocator: one request in, one result out.
// Request channel s_axis: tuser = operation (0 allocate, 1 free); tdata holds
// request_bytes and free_unit. Result channel m_axis: tuser = status; tdata
// holds block_unit, payload_offset and block_order. cfg_valid/cfg_data write
// the header byte count; write it only while no request is in flight.
// One request is worked on at a time. A free merges the block with its free
// buddies order by order; an allocate scans the 32-bit free map words from
// the first word of the needed order, climbs orders, then splits the found
// block down. The scan of the free map sets the worst case, for a small
// request on a full pool. After reset a clearing pass initializes both
// memories; requests are not taken until it ends.
// The result sits in an output register: a stalled receiver holds it there
// while the next request is already accepted and worked on; that request
// waits for the register before its result is posted.
// Depends on bba_pkg, bba_ctrl and bba_datapath.
`default_nettype none
module buddy_block_allocator_core #(
  parameter int TOP_BLOCKS = bba_pkg::DEF_TOP_BLOCKS,
  parameter int TOP_ORDER  = bba_pkg::DEF_TOP_ORDER
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [39:0] s_axis_tdata,  // request_bytes[19:0], free_unit[34:20], zero fill
  input  wire  [0:0]  s_axis_tuser,  // operation[0]
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [47:0] m_axis_tdata,  // block_unit[14:0], payload_offset[36:15],
                                     // block_order[40:37], zero fill
  output logic [1:0]  m_axis_tuser,  // status[1:0]
  input  wire         cfg_valid,
  output logic        cfg_ready,
  input  wire  [6:0]  cfg_data       // header_bytes
);
  import bba_pkg::*;

  ctrl_cmd_t           cmd;
  dp_status_t          st;
  logic [FU_W-1:0]     r_unit;
  logic [OFF_W-1:0]    r_off;
  logic [ORD_W-1:0]    r_ord;

  assign cfg_ready    = 1'b1;
  assign m_axis_tdata = {7'd0, r_ord, r_off, r_unit};

  bba_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .st       (st),
    .cmd      (cmd)
  );

  bba_datapath #(
    .TOP_BLOCKS (TOP_BLOCKS),
    .TOP_ORDER  (TOP_ORDER)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .st         (st),
    .cfg_valid  (cfg_valid),
    .cfg_data   (cfg_data),
    .in_op      (s_axis_tuser[0]),
    .in_req     (s_axis_tdata[19:0]),
    .in_fu      (s_axis_tdata[34:20]),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_status (m_axis_tuser),
    .out_unit   (r_unit),
    .out_off    (r_off),
    .out_ord    (r_ord)
  );

endmodule
`default_nettype wire
